// File: src/fbpa_pkg.sv
// Shared types and constants of the fixed block pool allocator.
package fbpa_pkg;

  localparam int REQ_BYTES_W   = 13;
  localparam int FREE_IDX_W    = 8;
  localparam int BLOCK_IDX_W   = 8;
  localparam int STATUS_W      = 2;
  localparam int NUM_BLOCKS_W  = 9;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 13;

  localparam logic [REQ_BYTES_W-1:0]  SMALL_BLOCK_BYTES  = 13'd32;
  localparam logic [NUM_BLOCKS_W-1:0] NUM_BLOCKS_RESET   = 9'd256;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BLOCKS  = 1'd1;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TOO_BIG   = 2'd1,
    STATUS_EXHAUSTED = 2'd2
  } status_t;

  typedef struct packed {
    logic [BLOCK_IDX_W-1:0] block_index;
    status_t                status;
  } rsp_t;

endpackage

// File: src/fbpa_if.sv
// Request and response channel interfaces of the fixed block pool allocator.
interface fbpa_req_if;
  logic                               valid;
  logic                               ready;
  logic                               op;
  logic [fbpa_pkg::REQ_BYTES_W-1:0]   request_bytes;
  logic [fbpa_pkg::FREE_IDX_W-1:0]    free_index;

  modport source (output valid, output op, output request_bytes, output free_index,
                  input ready);
  modport sink (input valid, input op, input request_bytes, input free_index,
                output ready);
endinterface

interface fbpa_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [fbpa_pkg::BLOCK_IDX_W-1:0]   block_index;
  logic [fbpa_pkg::STATUS_W-1:0]      status;

  modport source (output valid, output block_index, output status, input ready);
  modport sink (input valid, input block_index, input status, output ready);
endinterface

// File: src/fbpa_out_buf.sv
// Output register with a one-entry hold stage for allocator results.
module fbpa_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  fbpa_pkg::rsp_t      push_data,
  output logic                full,
  fbpa_rsp_if.source          out
);

  logic           out_valid_r;
  fbpa_pkg::rsp_t out_data_r;
  logic           hold_valid_r;
  fbpa_pkg::rsp_t hold_data_r;
  logic           drain;

  assign drain = out_valid_r && out.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
    end else if (drain || !out_valid_r) begin
      if (hold_valid_r) begin
        out_valid_r  <= 1'b1;
        out_data_r   <= hold_data_r;
        hold_valid_r <= push;
        hold_data_r  <= push_data;
      end else begin
        out_valid_r  <= push;
        out_data_r   <= push_data;
      end
    end else if (push) begin
      hold_valid_r <= 1'b1;
      hold_data_r  <= push_data;
    end
  end

  assign full            = hold_valid_r;
  assign out.valid       = out_valid_r;
  assign out.block_index = out_data_r.block_index;
  assign out.status      = out_data_r.status;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && hold_valid_r && !drain))
    else $error("result pushed while both result stages are occupied");

  a_hold_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    hold_valid_r |-> out_valid_r)
    else $error("hold stage occupied while output register is empty");

endmodule

// File: src/fixed_block_pool_allocator.sv
// Fixed block pool allocator: LIFO free list in a link memory with a bump counter behind it.
//
//   channel  | dir | handshake    | payload
//   in_req   | in  | valid/ready  | op, request_bytes, free_index
//   out_rsp  | out | valid/ready  | block_index, status
//   cfg_*    | in  | cfg_we only  | cfg_index, cfg_wdata
//
// A free, a refused allocate and a bump allocate push their result on acceptance;
// an allocate served from the free list goes through S_POP, which waits for the
// registered read of the link memory for the new head. Reset is synchronous and needs no
// clearing pass. One result may wait in the output stage while the next item
// is accepted; a second waiting result stops acceptance.
module fixed_block_pool_allocator #(
  parameter int POOL_DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  fbpa_req_if.sink                          in_req,
  fbpa_rsp_if.source                        out_rsp,
  input  logic                              cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int ADDR_W = $clog2(POOL_DEPTH);
  localparam int LINK_W = $clog2(POOL_DEPTH + 1);
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_DEPTH);

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_t;

  state_t                                state_r, state_nxt;
  logic [LINK_W-1:0]                     free_head_r, free_head_nxt;
  logic [LINK_W-1:0]                     next_unused_r, next_unused_nxt;
  logic [fbpa_pkg::REQ_BYTES_W-1:0]      block_bytes_r, block_bytes_nxt;
  logic [fbpa_pkg::NUM_BLOCKS_W-1:0]     num_blocks_r, num_blocks_nxt;

  logic [LINK_W-1:0]                     next_link [POOL_DEPTH];
  logic [LINK_W-1:0]                     rd_link_r;

  logic                                  accept;
  logic                                  is_free;
  logic                                  idx_ok;
  logic                                  head_valid;
  logic [LINK_W-1:0]                     usable;
  logic                                  push;
  fbpa_pkg::rsp_t                        push_data;
  logic                                  hold_full;

  assign accept     = in_req.valid && in_req.ready;
  assign is_free    = in_req.op == fbpa_pkg::OP_FREE;
  assign idx_ok     = 32'(in_req.free_index) < 32'(POOL_DEPTH);
  assign head_valid = free_head_r < NULL_LINK;
  assign usable     = (32'(num_blocks_r) > 32'(POOL_DEPTH)) ? NULL_LINK
                                                             : LINK_W'(num_blocks_r);
  assign in_req.ready = (state_r == S_IDLE) && !hold_full;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_link_r <= next_link[free_head_r[ADDR_W-1:0]];
      if (is_free && idx_ok) begin
        next_link[ADDR_W'(in_req.free_index)] <= free_head_r;
      end
    end
  end

  always_comb begin
    state_nxt       = state_r;
    free_head_nxt   = free_head_r;
    next_unused_nxt = next_unused_r;
    block_bytes_nxt = block_bytes_r;
    num_blocks_nxt  = num_blocks_r;
    push            = 1'b0;
    push_data       = '{block_index: '0, status: fbpa_pkg::STATUS_OK};

    if (cfg_we) begin
      case (cfg_index)
        fbpa_pkg::CFG_BLOCK_BYTES: block_bytes_nxt = cfg_wdata;
        fbpa_pkg::CFG_NUM_BLOCKS:  num_blocks_nxt  = cfg_wdata[fbpa_pkg::NUM_BLOCKS_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (is_free) begin
            push = 1'b1;
            if (idx_ok) begin
              free_head_nxt = LINK_W'(in_req.free_index);
            end
          end else if (in_req.request_bytes > block_bytes_r) begin
            push             = 1'b1;
            push_data.status = fbpa_pkg::STATUS_TOO_BIG;
          end else if (head_valid) begin
            state_nxt = S_POP;
          end else if (next_unused_r < usable) begin
            push                  = 1'b1;
            push_data.block_index = fbpa_pkg::BLOCK_IDX_W'(next_unused_r);
            next_unused_nxt       = LINK_W'(next_unused_r + 1'b1);
          end else begin
            push             = 1'b1;
            push_data.status = fbpa_pkg::STATUS_EXHAUSTED;
          end
        end
      end
      S_POP: begin
        push                  = 1'b1;
        push_data.block_index = fbpa_pkg::BLOCK_IDX_W'(free_head_r);
        free_head_nxt         = rd_link_r;
        state_nxt             = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      free_head_r   <= NULL_LINK;
      next_unused_r <= '0;
      block_bytes_r <= fbpa_pkg::SMALL_BLOCK_BYTES;
      num_blocks_r  <= fbpa_pkg::NUM_BLOCKS_RESET;
    end else begin
      state_r       <= state_nxt;
      free_head_r   <= free_head_nxt;
      next_unused_r <= next_unused_nxt;
      block_bytes_r <= block_bytes_nxt;
      num_blocks_r  <= num_blocks_nxt;
    end
  end

  fbpa_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (hold_full),
    .out       (out_rsp)
  );

  a_pop_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |-> head_valid)
    else $error("pop in progress with an empty free list");

  a_pop_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |=> (state_r == S_IDLE))
    else $error("pop did not finish after the link read");

  a_bump_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_unused_r <= NULL_LINK)
    else $error("bump counter ran past the pool depth");

endmodule
